// ===== hw/rtl/cltok_pkg.sv =====
package cltok_pkg;

	// Line and token limits
	localparam int MAX_LINE_BYTES = 256;
	localparam int MAX_TOKENS     = 16;

	// Counter widths: each counter must be able to hold its limit itself
	localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
	localparam int TOK_W = $clog2(MAX_TOKENS + 1);

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// Scanner modes
	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_QUOTE   = 3'd2,
		MODE_ESCAPE  = 3'd3,
		MODE_STOPPED = 3'd4
	} mode_t;

	// Line verdicts
	typedef enum logic [1:0] {
		VERDICT_NONE      = 2'd0,
		VERDICT_ACCEPTED  = 2'd1,
		VERDICT_MALFORMED = 2'd2,
		VERDICT_TOO_LONG  = 2'd3
	} verdict_t;

	// Per-line state
	typedef struct packed {
		logic [LEN_W-1:0] line_len;
		logic             overflowed;
		mode_t            mode;
		logic [TOK_W-1:0] tokens;
		logic             malformed;
	} line_state_t;

	// One result item
	typedef struct packed {
		logic [7:0] byte_echo;
		logic       kept;
		logic       in_token;
		logic       token_start;
		logic [3:0] token_index;
		logic       line_end;
		verdict_t   verdict;
		logic [4:0] token_count;
	} result_t;

endpackage

// ===== hw/rtl/cltok_scan.sv =====
module cltok_scan import cltok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_in,
	output result_t    res
);

	line_state_t cur_q;
	line_state_t nxt;
	logic        is_nl;
	logic        is_blank;
	logic [31:0] tok_wide;
	logic [31:0] idx_wide;

	assign is_nl    = (data_in == CH_LF) || (data_in == CH_CR);
	assign is_blank = (data_in == CH_SPACE) || (data_in == CH_TAB);

	// Result and next line state for the byte in the input stage
	always_comb begin
		res             = '0;
		res.byte_echo   = data_in;
		res.verdict     = VERDICT_NONE;
		nxt             = cur_q;
		tok_wide        = 32'(cur_q.tokens);
		idx_wide        = '0;
		if (is_nl) begin
			res.line_end = 1'b1;
			if (cur_q.overflowed) begin
				res.verdict = VERDICT_TOO_LONG;
			end else if (cur_q.line_len != '0) begin
				if (cur_q.malformed || cur_q.mode == MODE_QUOTE
						|| cur_q.mode == MODE_ESCAPE) begin
					res.verdict = VERDICT_MALFORMED;
				end else if (cur_q.tokens != '0) begin
					res.verdict     = VERDICT_ACCEPTED;
					res.token_count = tok_wide[4:0];
				end
			end
			nxt            = '0;
			nxt.mode       = MODE_BETWEEN;
		end else if (cur_q.overflowed) begin
			// dropped byte: nothing changes
		end else if (cur_q.line_len >= LEN_W'(MAX_LINE_BYTES)) begin
			nxt.overflowed = 1'b1;
		end else begin
			res.kept     = 1'b1;
			nxt.line_len = cur_q.line_len + 1'b1;
			if (data_in == CH_NUL) begin
				if (cur_q.mode == MODE_QUOTE || cur_q.mode == MODE_ESCAPE) begin
					nxt.malformed = 1'b1;
				end
				nxt.mode = MODE_STOPPED;
			end else begin
				unique case (cur_q.mode)
					MODE_BETWEEN: begin
						if (!is_blank) begin
							if (cur_q.tokens >= TOK_W'(MAX_TOKENS)) begin
								nxt.malformed = 1'b1;
								nxt.mode      = MODE_STOPPED;
							end else begin
								nxt.tokens      = cur_q.tokens + 1'b1;
								res.in_token    = 1'b1;
								res.token_start = 1'b1;
								nxt.mode = (data_in == CH_QUOTE) ? MODE_QUOTE : MODE_WORD;
							end
						end
					end
					MODE_WORD: begin
						if (is_blank) begin
							nxt.mode = MODE_BETWEEN;
						end else begin
							res.in_token = 1'b1;
						end
					end
					MODE_QUOTE: begin
						res.in_token = 1'b1;
						if (data_in == CH_QUOTE) begin
							nxt.mode = MODE_WORD;
						end else if (data_in == CH_BSL) begin
							nxt.mode = MODE_ESCAPE;
						end
					end
					MODE_ESCAPE: begin
						res.in_token = 1'b1;
						nxt.mode     = MODE_QUOTE;
					end
					default: begin
						nxt.mode = MODE_STOPPED;
					end
				endcase
			end
			// a byte in a token always has at least one token counted
			if (res.in_token) begin
				idx_wide        = 32'(nxt.tokens) - 32'd1;
				res.token_index = idx_wide[3:0];
			end
		end
	end

	// Line state register; all-zero is the between-tokens mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

	// A line end leaves the line state cleared
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_nl |=> cur_q.line_len == '0 && cur_q.tokens == '0 && !cur_q.overflowed)
		else $error("line state not cleared after line end");

	// Kept length never exceeds the limit
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.line_len <= LEN_W'(MAX_LINE_BYTES))
		else $error("line length beyond limit");

	// Token count never exceeds the limit
	a_tok_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.tokens <= TOK_W'(MAX_TOKENS))
		else $error("token count beyond limit");

	// Once stopped, only a line end leaves the stopped mode
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && cur_q.mode == MODE_STOPPED && !is_nl |=> cur_q.mode == MODE_STOPPED)
		else $error("scanner left stopped mode inside a line");

endmodule

// ===== hw/rtl/command_line_tokenizer.sv =====
// Command line tokenizer: takes one byte per item and returns one result item per
// byte, in order. A byte goes through an input register, the line scanner and an
// output register, and a new byte is taken in every cycle as long as results are
// taken; a stall on the result side reaches the input only once both registers
// are full. The line state (kept length, token count, quote mode, error flags)
// is updated as each byte leaves the input stage.
// Newline or carriage return ends a line and reports its verdict and token count.
module command_line_tokenizer import cltok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_echo,
	output logic       kept,
	output logic       in_token,
	output logic       token_start,
	output logic [3:0] token_index,
	output logic       line_end,
	output logic [1:0] verdict,
	output logic [4:0] token_count
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       adv_s1;
	logic       take_s2;

	// Pipeline flow
	assign take_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && take_s2;
	assign in_ready = !valid_s1 || take_s2;

	cltok_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.data_in (data_s1),
		.res     (res)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign byte_echo   = res_s2.byte_echo;
	assign kept        = res_s2.kept;
	assign in_token    = res_s2.in_token;
	assign token_start = res_s2.token_start;
	assign token_index = res_s2.token_index;
	assign line_end    = res_s2.line_end;
	assign verdict     = res_s2.verdict;
	assign token_count = res_s2.token_count;

	// A verdict only comes with a line end
	a_verdict_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.verdict != VERDICT_NONE |-> res_s2.line_end)
		else $error("verdict without line end");

	// Token start implies a kept token byte
	a_start_tok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.token_start |-> res_s2.in_token && res_s2.kept)
		else $error("token start outside a kept token byte");

	// Token count only with an accepted line
	a_count_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.token_count != '0 |-> res_s2.verdict == VERDICT_ACCEPTED)
		else $error("token count without accepted verdict");

	// A stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(res_s2))
		else $error("result changed while stalled");

endmodule

// ===== test/command_line_tokenizer_tb.sv =====
module command_line_tokenizer_tb import cltok_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS    = 700;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_PRINTED     = 40;

	// Directed row: a byte, and for line ends the verdict and count typed in by hand
	typedef struct packed {
		logic [7:0] data;
		logic       typed;
		verdict_t   verdict;
		logic [4:0] count;
	} stim_row_t;

	typedef enum {
		LINE_WELL_FORMED,
		LINE_MANY_TOKENS,
		LINE_LONG,
		LINE_BROKEN,
		LINE_NOISE
	} line_kind_t;

	localparam int DIRECTED_COUNT = 28;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// blank line straight out of reset
		'{CH_LF,    1'b1, VERDICT_NONE,      5'd0},
		// plain token, quoted token with an escaped quote and a tail, 0xFF token
		'{8'h61,    1'b0, VERDICT_NONE,      5'd0},
		'{CH_TAB,   1'b0, VERDICT_NONE,      5'd0},
		'{CH_QUOTE, 1'b0, VERDICT_NONE,      5'd0},
		'{CH_BSL,   1'b0, VERDICT_NONE,      5'd0},
		'{CH_QUOTE, 1'b0, VERDICT_NONE,      5'd0},
		'{CH_SPACE, 1'b0, VERDICT_NONE,      5'd0},
		'{CH_QUOTE, 1'b0, VERDICT_NONE,      5'd0},
		'{8'h7E,    1'b0, VERDICT_NONE,      5'd0},
		'{CH_SPACE, 1'b0, VERDICT_NONE,      5'd0},
		'{8'hFF,    1'b0, VERDICT_NONE,      5'd0},
		'{CH_CR,    1'b1, VERDICT_ACCEPTED,  5'd3},
		// zero byte inside a quote
		'{CH_QUOTE, 1'b0, VERDICT_NONE,      5'd0},
		'{CH_NUL,   1'b0, VERDICT_NONE,      5'd0},
		'{8'h62,    1'b0, VERDICT_NONE,      5'd0},
		'{CH_LF,    1'b1, VERDICT_MALFORMED, 5'd0},
		// backslash in a quote right before the line end
		'{CH_QUOTE, 1'b0, VERDICT_NONE,      5'd0},
		'{CH_BSL,   1'b0, VERDICT_NONE,      5'd0},
		'{CH_CR,    1'b1, VERDICT_MALFORMED, 5'd0},
		// a lone zero byte, then only blanks: both blank lines
		'{CH_NUL,   1'b0, VERDICT_NONE,      5'd0},
		'{CH_LF,    1'b1, VERDICT_NONE,      5'd0},
		'{CH_SPACE, 1'b0, VERDICT_NONE,      5'd0},
		'{CH_TAB,   1'b0, VERDICT_NONE,      5'd0},
		'{CH_CR,    1'b1, VERDICT_NONE,      5'd0},
		// zero byte after a plain token stops scanning without error
		'{8'h78,    1'b0, VERDICT_NONE,      5'd0},
		'{CH_NUL,   1'b0, VERDICT_NONE,      5'd0},
		'{8'h79,    1'b0, VERDICT_NONE,      5'd0},
		'{CH_LF,    1'b1, VERDICT_ACCEPTED,  5'd1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_echo;
	logic       kept;
	logic       in_token;
	logic       token_start;
	logic [3:0] token_index;
	logic       line_end;
	logic [1:0] verdict;
	logic [4:0] token_count;

	line_state_t cur_line = '0;
	result_t     pending_results [$];
	int          bytes_offered = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;
	bit          hold_off_req = 1'b0;

	command_line_tokenizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_echo   (byte_echo),
		.kept        (kept),
		.in_token    (in_token),
		.token_start (token_start),
		.token_index (token_index),
		.line_end    (line_end),
		.verdict     (verdict),
		.token_count (token_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Line scanner: advances the line state by one byte, returns its result
	function automatic result_t scan_byte(logic [7:0] c);
		result_t r;
		logic    blank;
		r = '0;
		r.byte_echo = c;
		blank = (c == CH_SPACE || c == CH_TAB);
		if (c == CH_LF || c == CH_CR) begin
			r.line_end = 1'b1;
			if (cur_line.overflowed) begin
				r.verdict = VERDICT_TOO_LONG;
			end else if (cur_line.line_len != 0) begin
				if (cur_line.malformed || cur_line.mode == MODE_QUOTE
						|| cur_line.mode == MODE_ESCAPE) begin
					r.verdict = VERDICT_MALFORMED;
				end else if (cur_line.tokens != 0) begin
					r.verdict = VERDICT_ACCEPTED;
					r.token_count = cur_line.tokens;
				end
			end
			cur_line = '0;
		end else if (cur_line.overflowed) begin
			// dropped byte, nothing changes
		end else if (cur_line.line_len >= MAX_LINE_BYTES) begin
			cur_line.overflowed = 1'b1;
		end else begin
			r.kept = 1'b1;
			cur_line.line_len++;
			if (c == CH_NUL) begin
				if (cur_line.mode == MODE_QUOTE || cur_line.mode == MODE_ESCAPE)
					cur_line.malformed = 1'b1;
				cur_line.mode = MODE_STOPPED;
			end else begin
				case (cur_line.mode)
					MODE_BETWEEN: begin
						if (!blank) begin
							if (cur_line.tokens >= MAX_TOKENS) begin
								// one token too many
								cur_line.malformed = 1'b1;
								cur_line.mode = MODE_STOPPED;
							end else begin
								cur_line.tokens++;
								r.in_token = 1'b1;
								r.token_start = 1'b1;
								cur_line.mode = (c == CH_QUOTE) ? MODE_QUOTE : MODE_WORD;
							end
						end
					end
					MODE_WORD: begin
						if (blank)
							cur_line.mode = MODE_BETWEEN;
						else
							r.in_token = 1'b1;
					end
					MODE_QUOTE: begin
						r.in_token = 1'b1;
						if (c == CH_QUOTE)
							cur_line.mode = MODE_WORD;
						else if (c == CH_BSL)
							cur_line.mode = MODE_ESCAPE;
					end
					MODE_ESCAPE: begin
						r.in_token = 1'b1;
						cur_line.mode = MODE_QUOTE;
					end
					default: cur_line.mode = MODE_STOPPED;
				endcase
			end
			if (r.in_token)
				r.token_index = 4'(cur_line.tokens - 1'b1);
		end
		return r;
	endfunction

	// Offer one byte; on acceptance queue its expected result item
	task automatic offer_byte(input logic [7:0] b, input logic typed = 1'b0,
			input verdict_t v = VERDICT_NONE, input logic [4:0] n = 5'd0);
		result_t predicted;
		if (!no_idle && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = scan_byte(b);
		bytes_offered++;
		if (typed)
			pending_results.push_back('{b, 1'b0, 1'b0, 1'b0, 4'd0, 1'b1, v, n});
		else
			pending_results.push_back(predicted);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] word_char(bit may_quote);
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB
			|| (!may_quote && c == CH_QUOTE));
		return c;
	endfunction

	task automatic send_blanks(input int count);
		repeat (count) offer_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
	endtask

	task automatic send_plain();
		offer_byte(word_char(1'b0));
		repeat ($urandom_range(0, 5)) offer_byte(word_char(1'b1));
	endtask

	// Quoted token with random escapes; optionally closed, maybe with a tail
	task automatic send_quoted(input bit closed);
		logic [7:0] c;
		offer_byte(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(4) == 0) begin
				offer_byte(CH_BSL);
				do c = 8'($urandom_range(1, 255)); while (c == CH_LF || c == CH_CR);
			end else begin
				do c = 8'($urandom_range(1, 255));
				while (c == CH_LF || c == CH_CR || c == CH_QUOTE || c == CH_BSL);
			end
			offer_byte(c);
		end
		if (closed) begin
			offer_byte(CH_QUOTE);
			repeat ($urandom_range(0, 1) * $urandom_range(1, 3)) offer_byte(word_char(1'b1));
		end
	endtask

	// One line of the given kind; amount fixes the token count or length if nonzero
	task automatic send_line(input line_kind_t kind, input int amount = 0);
		int ntok;
		case (kind) inside
			LINE_WELL_FORMED, LINE_MANY_TOKENS: begin
				if (kind == LINE_MANY_TOKENS)
					ntok = (amount != 0) ? amount
						: $urandom_range(MAX_TOKENS - 1, MAX_TOKENS + 2);
				else
					ntok = $urandom_range(0, 5);
				send_blanks($urandom_range(0, 2));
				for (int t = 0; t < ntok; t++) begin
					if (t != 0)
						send_blanks($urandom_range(1, 2));
					if ($urandom_range(2) == 0)
						send_quoted(1'b1);
					else
						send_plain();
				end
				send_blanks($urandom_range(0, 1));
			end
			LINE_BROKEN: begin
				send_plain();
				send_blanks(1);
				case ($urandom_range(3))
					0: send_quoted(1'b0);
					1: begin
						// zero byte inside a quote, scanning stops
						offer_byte(CH_QUOTE);
						offer_byte(CH_NUL);
						send_blanks(1);
						send_plain();
					end
					2: begin
						// zero byte right after a backslash
						offer_byte(CH_QUOTE);
						offer_byte(CH_BSL);
						offer_byte(CH_NUL);
						send_blanks(1);
						send_plain();
					end
					default: begin
						offer_byte(CH_QUOTE);
						offer_byte(CH_BSL);
					end
				endcase
			end
			LINE_LONG: begin
				repeat ((amount != 0) ? amount : MAX_LINE_BYTES - 1 + $urandom_range(0, 3))
					offer_byte(($urandom_range(4) == 0) ? CH_SPACE : word_char(1'b1));
			end
			default: begin
				repeat ($urandom_range(1, 12)) offer_byte(8'($urandom));
			end
		endcase
		offer_byte($urandom_range(1) ? CH_LF : CH_CR);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
	endtask

	// Result checker: compare each taken result item with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item, byte_echo", byte_echo, 0);
			end else begin
				want = pending_results.pop_front();
				if (byte_echo !== want.byte_echo)
					report_mismatch("byte_echo", byte_echo, want.byte_echo);
				if (kept !== want.kept)
					report_mismatch("kept", kept, want.kept);
				if (in_token !== want.in_token)
					report_mismatch("in_token", in_token, want.in_token);
				if (token_start !== want.token_start)
					report_mismatch("token_start", token_start, want.token_start);
				if (token_index !== want.token_index)
					report_mismatch("token_index", token_index, want.token_index);
				if (line_end !== want.line_end)
					report_mismatch("line_end", line_end, want.line_end);
				if (verdict !== want.verdict)
					report_mismatch("verdict", verdict, want.verdict);
				if (token_count !== want.token_count)
					report_mismatch("token_count", token_count, want.token_count);
			end
			results_seen++;
		end
	end

	// Result side: random stalls, quiet stretches, and a long hold-off on request
	initial begin : result_taker
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 10);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int pick;
		int random_start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			offer_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].verdict, DIRECTED_ROWS[i].count);

		// limits: exactly at and one past the token and length bounds
		send_line(LINE_MANY_TOKENS, MAX_TOKENS);
		send_line(LINE_MANY_TOKENS, MAX_TOKENS + 1);
		send_line(LINE_LONG, MAX_LINE_BYTES);
		send_line(LINE_LONG, MAX_LINE_BYTES + 1);

		random_start = bytes_offered;
		for (int line_no = 0; bytes_offered - random_start < RANDOM_ITEMS; line_no++) begin
			if (line_no == 3)
				hold_off_req = 1'b1;
			if (line_no == 8)
				wait_all_results();
			no_idle = (line_no >= 12 && line_no < 20);
			pick = $urandom_range(99);
			if (pick < 55)
				send_line(LINE_WELL_FORMED);
			else if (pick < 65)
				send_line(LINE_MANY_TOKENS);
			else if (pick < 68)
				send_line(LINE_LONG);
			else if (pick < 82)
				send_line(LINE_BROKEN);
			else
				send_line(LINE_NOISE);
		end

		no_idle = 1'b0;
		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
